FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define XTT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define XTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/xtt_pkg.sv
`default_nettype none

package xtt_pkg;

	localparam int TAG_DEPTH_DEF  = 16;
	localparam int DATA_DEPTH_DEF = 32;

	localparam int TAG_CAP_W  = 5;
	localparam int DATA_CAP_W = 6;
	localparam int CFG_W      = 6;

	localparam logic [TAG_CAP_W-1:0]  TAG_CAP_RST  = 5'd16;
	localparam logic [DATA_CAP_W-1:0] DATA_CAP_RST = 6'd32;

	localparam logic REG_TAG_CAP  = 1'b0;
	localparam logic REG_DATA_CAP = 1'b1;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_BANG  = 8'h21;

	localparam logic [1:0] EV_START = 2'd0;
	localparam logic [1:0] EV_END   = 2'd1;
	localparam logic [1:0] EV_TEXT  = 2'd2;

	typedef enum logic [2:0] {
		M_TEXT,
		M_NAME,
		M_TAG,
		M_DQUOTE,
		M_SQUOTE,
		M_COMMENT
	} mode_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_GATHER,
		E_OUT
	} estate_t;

	typedef enum logic [1:0] {
		SEG_START,
		SEG_END,
		SEG_TNAME,
		SEG_TBODY
	} seg_t;

	typedef struct packed {
		logic go;
		logic closing;
		logic self_close;
	} start_t;

	typedef struct packed {
		logic busy;
		logic last_pend;
	} emit_sts_t;

endpackage

`default_nettype wire

FILE: design/xtt_ram.sv
`default_nettype none

module xtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/xtt_emit.sv
`default_nettype none

`include "assert_macros.svh"

module xtt_emit #(
	parameter int TAG_DEPTH  = xtt_pkg::TAG_DEPTH_DEF,
	parameter int DATA_DEPTH = xtt_pkg::DATA_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire xtt_pkg::start_t               start,
	input  wire logic [$clog2(TAG_DEPTH)-1:0]  name_len,
	input  wire logic [$clog2(DATA_DEPTH)-1:0] text_len,
	output logic                               name_re,
	output logic      [$clog2(TAG_DEPTH)-1:0]  name_raddr,
	input  wire logic [7:0]                    name_rdata,
	output logic                               text_re,
	output logic      [$clog2(DATA_DEPTH)-1:0] text_raddr,
	input  wire logic [7:0]                    text_rdata,
	output xtt_pkg::emit_sts_t                 sts,
	output logic                               ev_valid,
	input  wire logic                          ev_stall,
	output logic      [1:0]                    event_kind,
	output logic                               part,
	output logic      [63:0]                   chunk,
	output logic      [3:0]                    byte_count,
	output logic                               event_end,
	output logic                               last
);

	localparam int NW = $clog2(TAG_DEPTH);
	localparam int TW = $clog2(DATA_DEPTH);
	localparam int PW = (NW > TW) ? NW : TW;

	xtt_pkg::estate_t state_q, state_d;
	xtt_pkg::seg_t    seg_q, seg_d, seg_after;
	logic [PW-1:0]    ipos_q, ipos_d, src_len;
	logic [3:0]       iss_q, iss_d;
	logic [3:0]       cnt_q, cnt_d;
	logic             rd_q;
	logic [2:0]       nres_q, nres_d;
	logic             self_q, self_d;
	logic [NW-1:0]    nlen_q, nlen_d;
	logic [TW-1:0]    tlen_q, tlen_d;
	logic [63:0]      chunk_q, chunk_d;
	logic             more, issue, final_seg;
	logic [7:0]       rdata;

	always_comb begin
		src_len   = (seg_q == xtt_pkg::SEG_TBODY) ? PW'(tlen_q) : PW'(nlen_q);
		more      = ipos_q < src_len;
		issue     = (state_q == xtt_pkg::E_GATHER) && (iss_q < 4'd8) && more;
		final_seg = (seg_q == xtt_pkg::SEG_END) || ((seg_q == xtt_pkg::SEG_START) && !self_q);
		rdata     = (seg_q == xtt_pkg::SEG_TBODY) ? text_rdata : name_rdata;
		case (seg_q)
			xtt_pkg::SEG_TNAME: seg_after = xtt_pkg::SEG_TBODY;
			default:            seg_after = xtt_pkg::SEG_END;
		endcase
		case (seg_q)
			xtt_pkg::SEG_START: event_kind = xtt_pkg::EV_START;
			xtt_pkg::SEG_END:   event_kind = xtt_pkg::EV_END;
			default:            event_kind = xtt_pkg::EV_TEXT;
		endcase
	end

	assign name_re    = issue && (seg_q != xtt_pkg::SEG_TBODY);
	assign text_re    = issue && (seg_q == xtt_pkg::SEG_TBODY);
	assign name_raddr = ipos_q[NW-1:0];
	assign text_raddr = ipos_q[TW-1:0];

	assign ev_valid   = (state_q == xtt_pkg::E_OUT);
	assign part       = (seg_q == xtt_pkg::SEG_TBODY);
	assign chunk      = chunk_q;
	assign byte_count = cnt_q;
	assign event_end  = !more && (seg_q != xtt_pkg::SEG_TNAME);
	assign last       = (nres_q == 3'd7) || (!more && final_seg);

	assign sts.busy      = (state_q != xtt_pkg::E_IDLE);
	assign sts.last_pend = ev_valid && last;

	always_comb begin
		state_d   = state_q;
		seg_d     = seg_q;
		ipos_d    = ipos_q;
		iss_d     = iss_q;
		cnt_d     = cnt_q;
		nres_d    = nres_q;
		self_d    = self_q;
		nlen_d    = nlen_q;
		tlen_d    = tlen_q;
		chunk_d   = chunk_q;
		case (state_q)
			xtt_pkg::E_IDLE: begin
				if (start.go) begin
					self_d    = start.self_close;
					nlen_d    = name_len;
					tlen_d    = text_len;
					if (!start.closing) begin
						seg_d = xtt_pkg::SEG_START;
					end else if (text_len != '0) begin
						seg_d = xtt_pkg::SEG_TNAME;
					end else begin
						seg_d = xtt_pkg::SEG_END;
					end
					ipos_d  = '0;
					iss_d   = '0;
					cnt_d   = '0;
					chunk_d = '0;
					nres_d  = '0;
					state_d = xtt_pkg::E_GATHER;
				end
			end
			xtt_pkg::E_GATHER: begin
				if (issue) begin
					ipos_d = ipos_q + PW'(1);
					iss_d  = iss_q + 4'd1;
				end
				if (rd_q) begin
					chunk_d[{cnt_q[2:0], 3'b000} +: 8] = rdata;
					cnt_d = cnt_q + 4'd1;
				end
				if (!issue && !rd_q) begin
					state_d = xtt_pkg::E_OUT;
				end
			end
			xtt_pkg::E_OUT: begin
				if (!ev_stall) begin
					nres_d = nres_q + 3'd1;
					if (last) begin
						state_d = xtt_pkg::E_IDLE;
					end else begin
						state_d = xtt_pkg::E_GATHER;
						iss_d   = '0;
						cnt_d   = '0;
						chunk_d = '0;
						if (!more) begin
							seg_d  = seg_after;
							ipos_d = '0;
						end
					end
				end
			end
			default: begin
				state_d = xtt_pkg::E_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= xtt_pkg::E_IDLE;
			seg_q     <= xtt_pkg::SEG_START;
			ipos_q    <= '0;
			iss_q     <= '0;
			cnt_q     <= '0;
			rd_q      <= 1'b0;
			nres_q    <= '0;
			self_q    <= 1'b0;
			nlen_q    <= '0;
			tlen_q    <= '0;
		end else begin
			state_q   <= state_d;
			seg_q     <= seg_d;
			ipos_q    <= ipos_d;
			iss_q     <= iss_d;
			cnt_q     <= cnt_d;
			rd_q      <= issue;
			nres_q    <= nres_d;
			self_q    <= self_d;
			nlen_q    <= nlen_d;
			tlen_q    <= tlen_d;
		end
	end

	always_ff @(posedge clk) begin
		chunk_q <= chunk_d;
	end

	`XTT_ASSERT(a_rd_in_gather, !rd_q || ((state_q == xtt_pkg::E_GATHER) && (cnt_q < 4'd8)), "read return outside gather")
	`XTT_ASSERT(a_empty_chunk, !ev_valid || (cnt_q != 4'd0) || (src_len == '0), "empty chunk from non-empty store")
	`XTT_ASSERT_NEXT(a_last_idle, ev_valid && !ev_stall && last, state_q == xtt_pkg::E_IDLE, "emitter busy after last request")

endmodule

`default_nettype wire

FILE: design/xml_tag_event_tokenizer.sv
// Channel  | Handshake            | Payload
// ch       | ch_valid / ch_stall  | ch
// ev       | ev_valid / ev_stall  | event_kind, part, chunk, byte_count, event_end, last
// cfg      | cfg_we               | cfg_index, cfg_data
//
// A closing '>' starts the event drain: each chunk is gathered through the single byte-wide
// read port of the name and text stores.
// The input may take a non-closing character while the final request waits.
// Reset returns to text mode with both stores empty; store contents are not cleared.
// A stall on ev holds the current request and the whole drain.
`default_nettype none

`include "assert_macros.svh"

module xml_tag_event_tokenizer #(
	parameter int TAG_DEPTH  = xtt_pkg::TAG_DEPTH_DEF,
	parameter int DATA_DEPTH = xtt_pkg::DATA_DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [xtt_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      ch_valid,
	output logic                           ch_stall,
	input  wire logic [7:0]                ch,
	output logic                           ev_valid,
	input  wire logic                      ev_stall,
	output logic      [1:0]                event_kind,
	output logic                           part,
	output logic      [63:0]               chunk,
	output logic      [3:0]                byte_count,
	output logic                           event_end,
	output logic                           last
);

	localparam int NW = $clog2(TAG_DEPTH);
	localparam int TW = $clog2(DATA_DEPTH);
	localparam logic [7:0] TAG_DEPTH_B  = 8'(TAG_DEPTH);
	localparam logic [7:0] DATA_DEPTH_B = 8'(DATA_DEPTH);

	logic [xtt_pkg::TAG_CAP_W-1:0]  tag_cap_q;
	logic [xtt_pkg::DATA_CAP_W-1:0] data_cap_q;

	xtt_pkg::mode_t mode_q, mode_d;
	logic           closing_q, closing_d;
	logic           self_q, self_d;
	logic [NW-1:0]  nlen_q, nlen_d;
	logic [TW-1:0]  tlen_q, tlen_d;
	logic [1:0]     dash_q, dash_d;
	logic           cm_q, cm_d;

	logic               ch_acc, close_now, blank;
	logic [7:0]         tlim, dlim;
	logic               name_fit, text_fit;
	logic               name_we, text_we;
	xtt_pkg::start_t    start;
	xtt_pkg::emit_sts_t sts;

	logic          name_re, text_re;
	logic [NW-1:0] name_raddr;
	logic [TW-1:0] text_raddr;
	logic [7:0]    name_rdata, text_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_cap_q  <= xtt_pkg::TAG_CAP_RST;
			data_cap_q <= xtt_pkg::DATA_CAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				xtt_pkg::REG_TAG_CAP:  tag_cap_q  <= cfg_data[xtt_pkg::TAG_CAP_W-1:0];
				xtt_pkg::REG_DATA_CAP: data_cap_q <= cfg_data[xtt_pkg::DATA_CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		close_now = (ch == xtt_pkg::CH_GT) && (mode_q inside {xtt_pkg::M_NAME, xtt_pkg::M_TAG});
		ch_stall  = sts.busy && !(sts.last_pend && !close_now);
		ch_acc    = ch_valid && !ch_stall;
		blank     = (ch == 8'h20) || (ch inside {[8'h09:8'h0D]});
		tlim      = (8'(tag_cap_q) < TAG_DEPTH_B) ? 8'(tag_cap_q) : TAG_DEPTH_B;
		dlim      = (8'(data_cap_q) < DATA_DEPTH_B) ? 8'(data_cap_q) : DATA_DEPTH_B;
		name_fit  = (8'(nlen_q) + 8'd1) < tlim;
		text_fit  = (8'(tlen_q) + 8'd1) < dlim;
	end

	always_comb begin
		mode_d           = mode_q;
		closing_d        = closing_q;
		self_d           = self_q;
		nlen_d           = nlen_q;
		tlen_d           = tlen_q;
		dash_d           = dash_q;
		cm_d             = cm_q;
		name_we          = 1'b0;
		text_we          = 1'b0;
		start.go         = 1'b0;
		start.closing    = closing_q;
		start.self_close = self_q;
		if (ch_acc) begin
			case (mode_q)
				xtt_pkg::M_NAME: begin
					if (blank) begin
						mode_d = xtt_pkg::M_TAG;
					end else if (ch == xtt_pkg::CH_SLASH) begin
						if (nlen_q == '0) begin
							closing_d = 1'b1;
						end else begin
							self_d = 1'b1;
							mode_d = xtt_pkg::M_TAG;
						end
					end else if (ch == xtt_pkg::CH_GT) begin
						start.go = 1'b1;
						tlen_d   = '0;
						mode_d   = xtt_pkg::M_TEXT;
					end else if (name_fit) begin
						name_we = 1'b1;
						nlen_d  = nlen_q + NW'(1);
						cm_d    = cm_q && (nlen_q < NW'(3)) &&
							(ch == ((nlen_q == '0) ? xtt_pkg::CH_BANG : xtt_pkg::CH_DASH));
					end
					if ((mode_d == xtt_pkg::M_TAG) && (nlen_q == NW'(3)) && cm_q) begin
						mode_d = xtt_pkg::M_COMMENT;
						dash_d = '0;
					end
				end
				xtt_pkg::M_TAG: begin
					if (ch == xtt_pkg::CH_DQ) begin
						mode_d = xtt_pkg::M_DQUOTE;
					end else if (ch == xtt_pkg::CH_SQ) begin
						mode_d = xtt_pkg::M_SQUOTE;
					end else if (ch == xtt_pkg::CH_SLASH) begin
						self_d = 1'b1;
					end else if (ch == xtt_pkg::CH_GT) begin
						start.go = 1'b1;
						tlen_d   = '0;
						mode_d   = xtt_pkg::M_TEXT;
					end
				end
				xtt_pkg::M_DQUOTE, xtt_pkg::M_SQUOTE: begin
					if (ch == ((mode_q == xtt_pkg::M_DQUOTE) ? xtt_pkg::CH_DQ : xtt_pkg::CH_SQ)) begin
						mode_d = xtt_pkg::M_TAG;
					end else if (ch == xtt_pkg::CH_LT) begin
						mode_d    = xtt_pkg::M_NAME;
						nlen_d    = '0;
						closing_d = 1'b0;
						self_d    = 1'b0;
						cm_d      = 1'b1;
					end
				end
				xtt_pkg::M_COMMENT: begin
					if (ch == xtt_pkg::CH_DASH) begin
						if (dash_q != 2'd2) begin
							dash_d = dash_q + 2'd1;
						end
					end else begin
						if ((ch == xtt_pkg::CH_GT) && (dash_q == 2'd2)) begin
							mode_d = xtt_pkg::M_TEXT;
						end
						dash_d = '0;
					end
				end
				default: begin
					if (ch == xtt_pkg::CH_LT) begin
						mode_d    = xtt_pkg::M_NAME;
						nlen_d    = '0;
						closing_d = 1'b0;
						self_d    = 1'b0;
						cm_d      = 1'b1;
					end else if (text_fit) begin
						text_we = 1'b1;
						tlen_d  = tlen_q + TW'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= xtt_pkg::M_TEXT;
			closing_q <= 1'b0;
			self_q    <= 1'b0;
			nlen_q    <= '0;
			tlen_q    <= '0;
			dash_q    <= '0;
			cm_q      <= 1'b1;
		end else begin
			mode_q    <= mode_d;
			closing_q <= closing_d;
			self_q    <= self_d;
			nlen_q    <= nlen_d;
			tlen_q    <= tlen_d;
			dash_q    <= dash_d;
			cm_q      <= cm_d;
		end
	end

	xtt_ram #(
		.WIDTH(8),
		.DEPTH(TAG_DEPTH)
	) u_name_ram (
		.clk  (clk),
		.we   (name_we),
		.waddr(nlen_q),
		.wdata(ch),
		.re   (name_re),
		.raddr(name_raddr),
		.rdata(name_rdata)
	);

	xtt_ram #(
		.WIDTH(8),
		.DEPTH(DATA_DEPTH)
	) u_text_ram (
		.clk  (clk),
		.we   (text_we),
		.waddr(tlen_q),
		.wdata(ch),
		.re   (text_re),
		.raddr(text_raddr),
		.rdata(text_rdata)
	);

	xtt_emit #(
		.TAG_DEPTH (TAG_DEPTH),
		.DATA_DEPTH(DATA_DEPTH)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.name_len  (nlen_q),
		.text_len  (tlen_q),
		.name_re   (name_re),
		.name_raddr(name_raddr),
		.name_rdata(name_rdata),
		.text_re   (text_re),
		.text_raddr(text_raddr),
		.text_rdata(text_rdata),
		.sts       (sts),
		.ev_valid  (ev_valid),
		.ev_stall  (ev_stall),
		.event_kind(event_kind),
		.part      (part),
		.chunk     (chunk),
		.byte_count(byte_count),
		.event_end (event_end),
		.last      (last)
	);

	`XTT_ASSERT(a_acc_pend, !(ch_acc && ev_valid) || last, "input taken with drain in progress")
	`XTT_ASSERT_NEXT(a_close_go, start.go, ch_stall, "input open right after closing tag")

endmodule

`default_nettype wire
